### rtl/pobs_pkg.sv
// Shared types, constants and helpers for the overlap box selector.
`timescale 1ns / 1ps
package pobs_pkg;

  localparam int MAX_BOXES = 32;
  localparam int IDX_W     = $clog2(MAX_BOXES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int RANK_W    = 18;
  localparam int PIX_W     = 13;

  typedef struct packed {
    logic [15:0] h;
    logic [15:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } rect_t;

  typedef struct packed {
    logic             in_load;
    logic [IDX_W-1:0] idx;
    logic             use_cur;
    logic             key_latch;
    logic             ahead_step;
    logic             order_wr;
    logic             cur_latch;
    logic             cur_rect_latch;
    logic             clash_step;
    logic             keep_commit;
    logic             out_load;
    logic             out_take;
    logic             clear;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] n_m1;
    logic             kept_here;
    logic             out_last;
  } sts_t;

  function automatic logic [PIX_W-1:0] round_px(input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, v} + 17'd8;
    return s[16:4];
  endfunction

endpackage

### rtl/pobs_dp.sv
// Datapath: box stores, ranking compare, overlap test and result register.
`timescale 1ns / 1ps
module pobs_dp import pobs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [1:0]       box_kind,
  input  logic [15:0]      box_score,
  input  logic [15:0]      box_x,
  input  logic [15:0]      box_y,
  input  logic [15:0]      box_w,
  input  logic [15:0]      box_h,
  output logic [4:0]       sel_index,
  output logic [PIX_W-1:0] kept_x,
  output logic [PIX_W-1:0] kept_y,
  output logic [PIX_W-1:0] kept_w,
  output logic [PIX_W-1:0] kept_h,
  output logic             overflowed,
  output logic             kept_last
);

  rect_t             rect_mem [MAX_BOXES];
  logic [RANK_W-1:0] rank_mem [MAX_BOXES];
  logic [IDX_W-1:0]  order_mem [MAX_BOXES];
  rect_t             rect_rd;
  logic [RANK_W-1:0] rank_rd;
  logic [IDX_W-1:0]  order_rd;

  logic [CNT_W-1:0]     box_count;
  logic                 overflow_flag;
  logic [MAX_BOXES-1:0] kept_flags;
  logic [CNT_W-1:0]     kept_cnt;
  logic [CNT_W-1:0]     done_cnt;
  logic [RANK_W-1:0]    key;
  logic [IDX_W-1:0]     key_idx;
  logic [IDX_W-1:0]     ahead;
  logic [IDX_W-1:0]     cur;
  rect_t                cur_rect;
  logic [31:0]          cur_area;
  logic                 clash;

  logic [IDX_W-1:0] rd_addr;
  logic             has_room;
  logic [CNT_W-1:0] count_m1;
  logic [CNT_W-1:0] done_inc;
  logic             ranks_ahead;
  logic [16:0]      cxr, cyr, jxr, jyr;
  logic [15:0]      mx, my;
  logic [16:0]      nxr, nyr;
  logic [31:0]      area_j;
  logic             meet, cur_holds, j_holds, hit;
  logic [PIX_W-1:0] rw, rh;

  assign rd_addr  = cmd.use_cur ? cur : cmd.idx;
  assign has_room = box_count < CNT_W'(MAX_BOXES);
  assign count_m1 = box_count - CNT_W'(1);
  assign done_inc = done_cnt + CNT_W'(1);

  assign sts.n_m1      = count_m1[IDX_W-1:0];
  assign sts.kept_here = kept_flags[cmd.idx];
  assign sts.out_last  = kept_last;

  assign ranks_ahead = (rank_rd > key) || ((rank_rd == key) && (cmd.idx < key_idx));

  always_comb begin
    cxr    = {1'b0, cur_rect.x} + {1'b0, cur_rect.w};
    cyr    = {1'b0, cur_rect.y} + {1'b0, cur_rect.h};
    jxr    = {1'b0, rect_rd.x} + {1'b0, rect_rd.w};
    jyr    = {1'b0, rect_rd.y} + {1'b0, rect_rd.h};
    mx     = (cur_rect.x > rect_rd.x) ? cur_rect.x : rect_rd.x;
    my     = (cur_rect.y > rect_rd.y) ? cur_rect.y : rect_rd.y;
    nxr    = (cxr < jxr) ? cxr : jxr;
    nyr    = (cyr < jyr) ? cyr : jyr;
    area_j = {16'd0, rect_rd.w} * {16'd0, rect_rd.h};
    meet   = ({1'b0, mx} < nxr) && ({1'b0, my} < nyr);
    cur_holds = (cur_area > area_j) && (cur_rect.x <= rect_rd.x) &&
                (cur_rect.y <= rect_rd.y) && (cxr >= jxr) && (cyr >= jyr);
    j_holds   = (area_j > cur_area) && (rect_rd.x <= cur_rect.x) &&
                (rect_rd.y <= cur_rect.y) && (jxr >= cxr) && (jyr >= cyr);
    hit = kept_flags[cmd.idx] && meet && !cur_holds && !j_holds;
    rw  = round_px(rect_rd.w);
    rh  = round_px(rect_rd.h);
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load && has_room) begin
      rect_mem[box_count[IDX_W-1:0]] <= {box_h, box_w, box_y, box_x};
      rank_mem[box_count[IDX_W-1:0]] <= {2'd3 - box_kind, box_score};
    end
    if (cmd.order_wr) begin
      order_mem[ahead] <= cmd.idx;
    end
    rect_rd  <= rect_mem[rd_addr];
    rank_rd  <= rank_mem[cmd.idx];
    order_rd <= order_mem[cmd.idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.key_latch) begin
      key     <= rank_rd;
      key_idx <= cmd.idx;
      ahead   <= '0;
    end else if (cmd.ahead_step && ranks_ahead) begin
      ahead <= ahead + IDX_W'(1);
    end
    if (cmd.cur_latch) begin
      cur <= order_rd;
    end
    if (cmd.cur_rect_latch) begin
      cur_rect <= rect_rd;
      cur_area <= {16'd0, rect_rd.w} * {16'd0, rect_rd.h};
      clash    <= 1'b0;
    end else if (cmd.clash_step && hit) begin
      clash <= 1'b1;
    end
    if (cmd.out_load) begin
      sel_index  <= 5'(cmd.idx);
      kept_x     <= round_px(rect_rd.x);
      kept_y     <= round_px(rect_rd.y);
      kept_w     <= (rw == '0) ? PIX_W'(1) : rw;
      kept_h     <= (rh == '0) ? PIX_W'(1) : rh;
      overflowed <= overflow_flag;
      kept_last  <= (done_inc == kept_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      box_count     <= '0;
      overflow_flag <= 1'b0;
      kept_flags    <= '0;
      kept_cnt      <= '0;
      done_cnt      <= '0;
    end else begin
      if (cmd.in_load) begin
        if (has_room) box_count <= box_count + CNT_W'(1);
        else overflow_flag <= 1'b1;
      end
      if (cmd.keep_commit && !clash) begin
        kept_flags[cur] <= 1'b1;
        kept_cnt        <= kept_cnt + CNT_W'(1);
      end
      if (cmd.out_take) done_cnt <= done_inc;
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    box_count <= CNT_W'(MAX_BOXES))
    else $error("box count beyond capacity");
  a_kept_le_count: assert property (@(posedge clk) disable iff (rst)
    kept_cnt <= box_count)
    else $error("more kept boxes than stored");
  a_emit_kept: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> kept_flags[cmd.idx])
    else $error("emitting a box that was not kept");

endmodule

### rtl/pobs_ctrl.sv
// Controller: sequences loading, ranking, suppression and result beats.
`timescale 1ns / 1ps
module pobs_ctrl import pobs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic box_last,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_LOAD, S_RK_I, S_RK_IL, S_RK_J, S_RK_JC, S_RK_W,
    S_SEL_C, S_SEL_CL, S_SEL_CR, S_SEL_CRL, S_SEL_J, S_SEL_JC, S_SEL_K,
    S_OUT_SCAN, S_OUT_LOAD, S_OUT_WAIT
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] i, j, pos, k;

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_OUT_WAIT);

  always_comb begin
    cmd = '0;
    case (state)
      S_LOAD:     cmd.in_load = in_valid;
      S_RK_I:     cmd.idx = i;
      S_RK_IL:    begin cmd.idx = i; cmd.key_latch = 1'b1; end
      S_RK_J:     cmd.idx = j;
      S_RK_JC:    begin cmd.idx = j; cmd.ahead_step = 1'b1; end
      S_RK_W:     begin cmd.idx = i; cmd.order_wr = 1'b1; end
      S_SEL_C:    cmd.idx = pos;
      S_SEL_CL:   cmd.cur_latch = 1'b1;
      S_SEL_CR:   cmd.use_cur = 1'b1;
      S_SEL_CRL:  cmd.cur_rect_latch = 1'b1;
      S_SEL_J:    cmd.idx = j;
      S_SEL_JC:   begin cmd.idx = j; cmd.clash_step = 1'b1; end
      S_SEL_K:    cmd.keep_commit = 1'b1;
      S_OUT_SCAN: cmd.idx = k;
      S_OUT_LOAD: begin cmd.idx = k; cmd.out_load = 1'b1; end
      S_OUT_WAIT: begin
        cmd.idx      = k;
        cmd.out_take = out_ready;
        cmd.clear    = out_ready && sts.out_last;
      end
      default:    cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      i     <= '0;
      j     <= '0;
      pos   <= '0;
      k     <= '0;
    end else begin
      case (state)
        S_LOAD: if (in_valid && box_last) begin
          i     <= '0;
          state <= S_RK_I;
        end
        S_RK_I:  state <= S_RK_IL;
        S_RK_IL: begin
          j     <= '0;
          state <= S_RK_J;
        end
        S_RK_J:  state <= S_RK_JC;
        S_RK_JC: begin
          if (j == sts.n_m1) state <= S_RK_W;
          else begin
            j     <= j + IDX_W'(1);
            state <= S_RK_J;
          end
        end
        S_RK_W: begin
          if (i == sts.n_m1) begin
            pos   <= '0;
            state <= S_SEL_C;
          end else begin
            i     <= i + IDX_W'(1);
            state <= S_RK_I;
          end
        end
        S_SEL_C:   state <= S_SEL_CL;
        S_SEL_CL:  state <= S_SEL_CR;
        S_SEL_CR:  state <= S_SEL_CRL;
        S_SEL_CRL: begin
          j     <= '0;
          state <= S_SEL_J;
        end
        S_SEL_J:  state <= S_SEL_JC;
        S_SEL_JC: begin
          if (j == sts.n_m1) state <= S_SEL_K;
          else begin
            j     <= j + IDX_W'(1);
            state <= S_SEL_J;
          end
        end
        S_SEL_K: begin
          if (pos == sts.n_m1) begin
            k     <= '0;
            state <= S_OUT_SCAN;
          end else begin
            pos   <= pos + IDX_W'(1);
            state <= S_SEL_C;
          end
        end
        S_OUT_SCAN: begin
          if (sts.kept_here) state <= S_OUT_LOAD;
          else k <= k + IDX_W'(1);
        end
        S_OUT_LOAD: state <= S_OUT_WAIT;
        S_OUT_WAIT: if (out_ready) begin
          if (sts.out_last) state <= S_LOAD;
          else begin
            k     <= k + IDX_W'(1);
            state <= S_OUT_SCAN;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

### rtl/priority_overlap_box_selector_unit.sv
// Top level of the priority overlap box selector.
//
// Input channel (in_valid/in_ready): one box per beat, kind, score and
// Q12.4 rectangle. Boxes load at one beat per cycle into the box store;
// beyond MAX_BOXES they are dropped and the set is flagged as overflowed.
// A beat with box_last set closes the set and starts selection; in_ready
// stays low until the final result beat has been taken.
// Ranking walks every pair of stored boxes through one store read port,
// one pair at a time. The suppression pass walks every stored box against
// each candidate the same way, testing only those already kept. Result
// beats then follow in arrival order, one per kept box.
// Output channel (out_valid/out_ready): the result register holds its
// beat while out_ready is low; nothing advances until it is taken.
// kept_last marks the final beat of a set, after which the block is empty.
// Reset (rst, synchronous) empties the store and returns to loading.
`timescale 1ns / 1ps
module priority_overlap_box_selector_unit import pobs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       box_kind,
  input  logic [15:0]      box_score,
  input  logic [15:0]      box_x,
  input  logic [15:0]      box_y,
  input  logic [15:0]      box_w,
  input  logic [15:0]      box_h,
  input  logic             box_last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [4:0]       sel_index,
  output logic [PIX_W-1:0] kept_x,
  output logic [PIX_W-1:0] kept_y,
  output logic [PIX_W-1:0] kept_w,
  output logic [PIX_W-1:0] kept_h,
  output logic             overflowed,
  output logic             kept_last
);

  cmd_t cmd;
  sts_t sts;

  pobs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .box_last  (box_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pobs_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .box_kind   (box_kind),
    .box_score  (box_score),
    .box_x      (box_x),
    .box_y      (box_y),
    .box_w      (box_w),
    .box_h      (box_h),
    .sel_index  (sel_index),
    .kept_x     (kept_x),
    .kept_y     (kept_y),
    .kept_w     (kept_w),
    .kept_h     (kept_h),
    .overflowed (overflowed),
    .kept_last  (kept_last)
  );

endmodule

### sim/priority_overlap_box_selector_unit_tb.sv
// Self-checking testbench for the priority overlap box selector unit.
`timescale 1ns / 1ps
module priority_overlap_box_selector_unit_tb;
  import pobs_pkg::*;

  typedef struct packed {
    logic [4:0]       index;
    logic [PIX_W-1:0] x, y, w, h;
    logic             ovf, last;
  } kept_box_t;

  class nms_scoreboard;
    rect_t       rects[$];
    logic [17:0] keys[$];
    bit          dropped;
    kept_box_t   pending[$];
    int          mismatches, beats_checked, sets_closed;

    function automatic bit meets(rect_t a, rect_t b);
      logic [16:0] ra, rb, ba, bb;
      ra = a.x + a.w; rb = b.x + b.w; ba = a.y + a.h; bb = b.y + b.h;
      return ((a.x > b.x ? a.x : b.x) < (ra < rb ? ra : rb)) &&
             ((a.y > b.y ? a.y : b.y) < (ba < bb ? ba : bb));
    endfunction

    function automatic bit holds(rect_t o, rect_t i);
      logic [31:0] ao, ai;
      ao = o.w * o.h; ai = i.w * i.h;
      return ao > ai && o.x <= i.x && o.y <= i.y &&
             {1'b0, o.x} + o.w >= {1'b0, i.x} + i.w &&
             {1'b0, o.y} + o.h >= {1'b0, i.y} + i.h;
    endfunction

    function automatic logic [PIX_W-1:0] to_px(logic [15:0] v);
      logic [16:0] s;
      s = {1'b0, v} + 17'd8;
      return s[16:4];
    endfunction

    function void note_box(logic [1:0] kind, logic [15:0] score, rect_t r, logic last);
      int n, order[$], cnt, done;
      bit kept[$];
      kept_box_t k;
      if (rects.size() < MAX_BOXES) begin
        rects.insert(rects.size(), r);
        keys.insert(keys.size(), {2'd3 - kind, score});
      end else dropped = 1;
      if (!last) return;
      n = rects.size();
      for (int i = 0; i < n; i++) begin
        int p;
        p = 0;
        while (p < order.size() && keys[order[p]] >= keys[i]) p++;
        order.insert(p, i);
        kept.insert(kept.size(), 1'b0);
      end
      foreach (order[p]) begin
        bit clash;
        clash = 0;
        for (int j = 0; j < n; j++)
          if (kept[j] && meets(rects[order[p]], rects[j]) &&
              !holds(rects[order[p]], rects[j]) && !holds(rects[j], rects[order[p]]))
            clash = 1;
        if (!clash) kept[order[p]] = 1;
      end
      cnt = 0;
      foreach (kept[i]) if (kept[i]) cnt++;
      done = 0;
      for (int i = 0; i < n; i++) if (kept[i]) begin
        k.index = i[4:0];
        k.x = to_px(rects[i].x); k.y = to_px(rects[i].y);
        k.w = to_px(rects[i].w); k.h = to_px(rects[i].h);
        if (k.w == 0) k.w = 1;
        if (k.h == 0) k.h = 1;
        k.ovf = dropped; done++; k.last = (done == cnt);
        pending.insert(pending.size(), k);
      end
      rects.delete(); keys.delete(); dropped = 0; sets_closed++;
    endfunction

    function void check_beat(kept_box_t a);
      kept_box_t e;
      beats_checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat idx %0d", a.index);
        return;
      end
      e = pending.pop_front();
      if (a != e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp %0d %0d %0d %0d %0d %0b %0b got %0d %0d %0d %0d %0d %0b %0b",
                   e.index, e.x, e.y, e.w, e.h, e.ovf, e.last,
                   a.index, a.x, a.y, a.w, a.h, a.ovf, a.last);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1, in_valid = 0, out_ready = 0, box_last = 0;
  logic in_ready, out_valid, overflowed, kept_last;
  logic [1:0] box_kind = 0;
  logic [15:0] box_score = 0, box_x = 0, box_y = 0, box_w = 0, box_h = 0;
  logic [4:0] sel_index;
  logic [PIX_W-1:0] kept_x, kept_y, kept_w, kept_h;
  int idle_pct = 21;
  nms_scoreboard board = new();

  priority_overlap_box_selector_unit DUT (.*);

  initial forever #6 clk = ~clk;

  always @(posedge clk) if (!rst) begin
    if (in_valid && in_ready)
      board.note_box(box_kind, box_score, '{h: box_h, w: box_w, y: box_y, x: box_x},
                     box_last);
    if (out_valid && out_ready)
      board.check_beat('{sel_index, kept_x, kept_y, kept_w, kept_h, overflowed, kept_last});
  end

  initial begin
    @(negedge clk);
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // valid stays up after the beat; the next box or drain decides what follows
  task automatic send_box(logic [1:0] k, logic [15:0] s, x, y, w, h, logic last);
    while (!rst && $urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; box_kind <= k; box_score <= s;
    box_x <= x; box_y <= y; box_w <= w; box_h <= h; box_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_set(int n, bit clustered);
    logic [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      if (clustered) begin
        x = 16'($urandom_range(2000)); y = 16'($urandom_range(2000));
        send_box(2'($urandom), $urandom_range(3) == 0 ? 16'd500 : 16'($urandom), x, y,
                 16'($urandom_range(800)), 16'($urandom_range(800)), i == n - 1);
      end else
        send_box(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), i == n - 1);
    end
  endtask

  task automatic drain;
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  int sent;

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: extremes, containment, abutment, zero size, equal keys
    send_box(2'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_box(2'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_box(2'd1, 16'd100, 16'd0, 16'd0, 16'd320, 16'd320, 1'b0);
    send_box(2'd2, 16'd100, 16'd16, 16'd16, 16'd64, 16'd64, 1'b0);
    send_box(2'd2, 16'd100, 16'd320, 16'd0, 16'd64, 16'd64, 1'b0);
    send_box(2'd2, 16'd100, 16'd300, 16'd0, 16'd64, 16'd64, 1'b0);
    send_box(2'd3, 16'd7, 16'd0, 16'd0, 16'd320, 16'd320, 1'b0);
    send_box(2'd1, 16'd100, 16'd7, 16'd8, 16'd9, 16'd24, 1'b1);
    drain();
    send_box(2'd3, 16'd1, 16'd8, 16'd8, 16'd7, 16'd7, 1'b1);
    drain();
    for (int i = 0; i < MAX_BOXES + 3; i++)
      send_box(i[1:0], 16'd5, 16'(i * 40), 16'd0, 16'd48, 16'd48, i == MAX_BOXES + 2);
    drain();
    sent = 44;
    idle_pct = 0;
    while (sent < 150) begin
      int n;
      n = $urandom_range(1, 8);
      random_set(n, 1); sent += n;
    end
    drain();
    idle_pct = 21;
    while (sent < 500) begin
      int n;
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 10);
      random_set(n, $urandom_range(4) != 0); sent += n;
      if ($urandom_range(7) == 0) drain();
    end
    drain();
    repeat (50) @(negedge clk);
    $display("Ran %0d boxes in %0d sets, checked %0d kept-box beats.",
             sent, board.sets_closed, board.beats_checked);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #60ms;
    $display("Timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

### priority_overlap_box_selector_unit.f
rtl/pobs_pkg.sv
rtl/pobs_dp.sv
rtl/pobs_ctrl.sv
rtl/priority_overlap_box_selector_unit.sv
sim/priority_overlap_box_selector_unit_tb.sv
